[sv/mdtp_pkg.sv]
`default_nettype none

package mdtp_pkg;

    localparam int unsigned MAX_DRUMS  = 6;
    localparam int unsigned CLAP_DRUM  = 2;
    localparam int unsigned NOISE_PIN  = 6;
    localparam int unsigned ACCENT_PIN = 7;

    localparam int unsigned NOTE_W = 7;
    localparam int unsigned CNT_W  = 8;
    localparam int unsigned ACC_W  = 5;
    localparam int unsigned PIN_W  = 8;
    localparam int unsigned IDX_W  = 3;

    // command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_EVENT = 1'b1;

    localparam logic [3:0] NOTE_ON_NIBBLE = 4'h9;

    // counter loads
    localparam logic [CNT_W-1:0] CLAP_LOAD   = 8'd140;
    localparam logic [CNT_W-1:0] DRUM_LOAD   = 8'd20;
    localparam logic [ACC_W-1:0] ACCENT_LOAD = 5'd20;
    localparam logic [CNT_W-1:0] CNT_STEP    = 8'd2;

    // clap sequence points
    localparam logic [CNT_W-1:0] CLAP_HIGH_A = 8'd120;
    localparam logic [CNT_W-1:0] CLAP_HIGH_B = 8'd80;
    localparam logic [CNT_W-1:0] CLAP_HIGH_C = 8'd40;
    localparam logic [CNT_W-1:0] CLAP_LOW_A  = 8'd100;
    localparam logic [CNT_W-1:0] CLAP_LOW_B  = 8'd60;
    localparam logic [CNT_W-1:0] NOISE_ON    = 8'd20;

    // register map, by word index
    localparam logic [IDX_W-1:0] REG_DRUM0      = 3'd0;
    localparam logic [IDX_W-1:0] REG_ACCENT_THR = 3'd6;

    localparam logic [MAX_DRUMS-1:0][NOTE_W-1:0] NOTE_RESET =
        {7'd49, 7'd46, 7'd42, 7'd39, 7'd38, 7'd36};
    localparam logic [NOTE_W-1:0] ACCENT_THR_RESET = 7'd100;
    localparam logic [PIN_W-1:0]  PINS_RESET       = 8'hFF;

    typedef struct packed {
        logic                   command;
        logic [7:0]             status_byte;
        logic [NOTE_W-1:0]      note_number;
        logic [NOTE_W-1:0]      velocity;
    } t_item;

    typedef struct packed {
        logic [MAX_DRUMS-1:0][NOTE_W-1:0] note;
        logic [NOTE_W-1:0]                accent_thr;
    } t_cfg;

endpackage

`default_nettype wire

[sv/mdtp_cfg.sv]
`default_nettype none

module mdtp_cfg
    import mdtp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg             r_cfg;
    logic [IDX_W-1:0] reg_idx;
    logic             wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.note       <= NOTE_RESET;
            r_cfg.accent_thr <= ACCENT_THR_RESET;
        end else if (wr_en) begin
            if (reg_idx < REG_ACCENT_THR) begin
                r_cfg.note[reg_idx] <= pwdata[NOTE_W-1:0];
            end else if (reg_idx == REG_ACCENT_THR) begin
                r_cfg.accent_thr <= pwdata[NOTE_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx < REG_ACCENT_THR) begin
            prdata = {{(32-NOTE_W){1'b0}}, r_cfg.note[reg_idx]};
        end else if (reg_idx == REG_ACCENT_THR) begin
            prdata = {{(32-NOTE_W){1'b0}}, r_cfg.accent_thr};
        end
    end

endmodule

`default_nettype wire

[sv/mdtp_engine.sv]
`default_nettype none

module mdtp_engine
    import mdtp_pkg::*;
#(
    parameter int unsigned DRUM_COUNT = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire t_item            i_item,
    input  wire t_cfg             i_cfg,
    output logic      [PIN_W-1:0] o_pins
);

    logic [CNT_W-1:0] r_cnt [DRUM_COUNT];
    logic [CNT_W-1:0] n_cnt [DRUM_COUNT];
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [PIN_W-1:0] r_pins, n_pins;
    logic             note_on;
    logic             found;

    assign note_on = (i_item.status_byte[7:4] == NOTE_ON_NIBBLE) && (i_item.velocity != '0);
    assign o_pins  = n_pins;

    always_comb begin
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_pins = r_pins;
        found  = 1'b0;
        if (i_item.command == CMD_TICK) begin
            for (int i = 0; i < DRUM_COUNT; i++) begin
                if (r_cnt[i] != '0) begin
                    n_cnt[i] = (r_cnt[i] >= CNT_STEP) ? r_cnt[i] - CNT_STEP : '0;
                    if (i == CLAP_DRUM) begin
                        if (n_cnt[i] inside {CLAP_HIGH_A, CLAP_HIGH_B, CLAP_HIGH_C}) begin
                            n_pins[i] = 1'b1;
                        end else if (n_cnt[i] inside {CLAP_LOW_A, CLAP_LOW_B}) begin
                            n_pins[i] = 1'b0;
                        end else if (n_cnt[i] == NOISE_ON) begin
                            n_pins[NOISE_PIN] = 1'b0;
                        end else if (n_cnt[i] == '0) begin
                            n_pins[NOISE_PIN] = 1'b1;
                        end
                    end else if (n_cnt[i] == '0) begin
                        n_pins[i] = 1'b1;
                    end
                end
            end
            if (r_acc != '0) begin
                n_acc = r_acc - 1'b1;
                if (n_acc == '0) begin
                    n_pins[ACCENT_PIN] = 1'b1;
                end
            end
        end else if (note_on) begin
            // lowest numbered matching drum wins
            for (int i = 0; i < DRUM_COUNT; i++) begin
                if (!found && (i_cfg.note[i] == i_item.note_number)) begin
                    found     = 1'b1;
                    n_pins[i] = 1'b0;
                    n_cnt[i]  = (i == CLAP_DRUM) ? CLAP_LOAD : DRUM_LOAD;
                end
            end
            if (i_item.velocity > i_cfg.accent_thr) begin
                n_acc              = ACCENT_LOAD;
                n_pins[ACCENT_PIN] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DRUM_COUNT; i++) begin
                r_cnt[i] <= '0;
            end
            r_acc  <= '0;
            r_pins <= PINS_RESET;
        end else if (i_step) begin
            r_cnt  <= n_cnt;
            r_acc  <= n_acc;
            r_pins <= n_pins;
        end
    end

endmodule

`default_nettype wire

[sv/midi_drum_trigger_pulser.sv]
// MIDI drum trigger pulser.
// Input channel (i_in_valid / o_in_ready): each transaction is either a
// timer tick (i_command = 0) or a MIDI event (i_command = 1). A note-on with
// nonzero velocity fires the first configured drum whose note matches and,
// when velocity exceeds the accent threshold, restarts the accent pulse.
// Output channel (o_out_valid / i_out_ready): one transaction per input,
// carrying the eight active-low pin levels after that step.
// Pipeline: an input register feeds the step logic, whose result is captured
// in the output register while the engine commits the updated counters. One
// item per cycle is sustained because the input register refills while the
// output is taken.
// If the receiver stalls, the output holds, the input register keeps one
// more item, and o_in_ready drops only when both are full.
// Configuration is an APB-style port, one register per 32-bit word:
// drum0..drum5 notes at 0x00..0x14, accent threshold at 0x18. Write only
// while the block is idle. Reset (synchronous, active low) empties both
// stages, zeroes all counters, sets every pin high and reloads the default
// drum notes and threshold.
`default_nettype none

module midi_drum_trigger_pulser
    import mdtp_pkg::*;
#(
    parameter int unsigned DRUM_COUNT = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input channel
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_command,
    input  wire logic [7:0]        i_status_byte,
    input  wire logic [NOTE_W-1:0] i_note_number,
    input  wire logic [NOTE_W-1:0] i_velocity,
    // output channel
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic      [PIN_W-1:0]  o_trigger_pins,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    t_cfg             cfg;
    t_item            r_item;
    logic             r_in_valid;
    logic             r_out_valid;
    logic [PIN_W-1:0] r_out_pins;
    logic [PIN_W-1:0] step_pins;
    logic             in_fire;
    logic             advance;

    // input stage moves on whenever the output slot is free or being freed
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    assign o_out_valid    = r_out_valid;
    assign o_trigger_pins = r_out_pins;

    mdtp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // counters and pin state commit only when the step result is registered
    mdtp_engine #(
        .DRUM_COUNT (DRUM_COUNT)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_pins  (step_pins)
    );

    // input register: payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item.command     <= i_command;
            r_item.status_byte <= i_status_byte;
            r_item.note_number <= i_note_number;
            r_item.velocity    <= i_velocity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_pins <= step_pins;
        end
    end

endmodule

`default_nettype wire

[sv/mdtp_checker.sv]
`default_nettype none

module mdtp_checker
    import mdtp_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_ready,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire logic [PIN_W-1:0] o_trigger_pins
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_trigger_pins)))
        else $error("stalled output changed");

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // backpressure only comes from a full output
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // a valid result shows once an accepted item has passed both registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> ##2 o_out_valid)
        else $error("result missing two cycles after input");

endmodule

bind midi_drum_trigger_pulser mdtp_checker u_mdtp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_trigger_pins (o_trigger_pins)
);

`default_nettype wire

[bench/tb_midi_drum_trigger_pulser.sv]
module tb_midi_drum_trigger_pulser
    import mdtp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DRUMS_USED     = 6;
    localparam int unsigned DRAIN_CYCLES   = 4;
    localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
    localparam int unsigned RANDOM_ITEMS   = 220;   // per idling phase

    // config index with no register behind it, write must be dropped
    localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd7;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_in_valid    = 1'b0;
    logic              o_in_ready;
    logic              i_command     = CMD_TICK;
    logic [7:0]        i_status_byte = '0;
    logic [NOTE_W-1:0] i_note_number = '0;
    logic [NOTE_W-1:0] i_velocity    = '0;
    logic              o_out_valid;
    logic              i_out_ready   = 1'b0;
    logic [PIN_W-1:0]  o_trigger_pins;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [4:0]        paddr         = '0;
    logic [31:0]       pwdata        = '0;
    logic [31:0]       prdata;
    logic              pready;

    midi_drum_trigger_pulser #(
        .DRUM_COUNT (DRUMS_USED)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_status_byte  (i_status_byte),
        .i_note_number  (i_note_number),
        .i_velocity     (i_velocity),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_trigger_pins (o_trigger_pins),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Pin predictor: private copy of config and counters, stepped once per
    // accepted input transaction.
    // ------------------------------------------------------------------
    logic [NOTE_W-1:0] drum_note_cfg [MAX_DRUMS];
    logic [NOTE_W-1:0] accent_thr_cfg;
    logic [CNT_W-1:0]  drum_cnt [MAX_DRUMS];
    logic [ACC_W-1:0]  accent_cnt;
    logic [PIN_W-1:0]  pin_state;

    logic [PIN_W-1:0]  exp_pins_q [$];   // predicted pin levels, oldest first
    logic [PIN_W-1:0]  pins_due;
    int unsigned       error_count = 0;
    int unsigned       idle_cycles = 0;

    // idling knobs, percent per cycle
    int unsigned       send_gap_pct    = 0;
    int unsigned       ready_stall_pct = 0;

    function automatic void reset_predictor();
        int k;
        for (k = 0; k < MAX_DRUMS; k++) begin
            drum_note_cfg[k] = NOTE_RESET[k];
            drum_cnt[k]      = '0;
        end
        accent_thr_cfg = ACCENT_THR_RESET;
        accent_cnt     = '0;
        pin_state      = PINS_RESET;
    endfunction

    function automatic logic [PIN_W-1:0] step_pins(input t_item it);
        int k;
        logic [CNT_W-1:0] cnt;
        logic hit;
        hit = 1'b0;
        if (it.command == CMD_TICK) begin
            for (k = 0; k < DRUMS_USED; k++) begin
                if (drum_cnt[k] != '0) begin
                    // saturating, so an odd count can never wrap
                    cnt = (drum_cnt[k] >= CNT_STEP) ? drum_cnt[k] - CNT_STEP : '0;
                    drum_cnt[k] = cnt;
                    if (k == CLAP_DRUM) begin
                        if (cnt == CLAP_HIGH_A || cnt == CLAP_HIGH_B || cnt == CLAP_HIGH_C)
                            pin_state[k] = 1'b1;
                        else if (cnt == CLAP_LOW_A || cnt == CLAP_LOW_B)
                            pin_state[k] = 1'b0;
                        else if (cnt == NOISE_ON)
                            pin_state[NOISE_PIN] = 1'b0;
                        else if (cnt == '0)
                            pin_state[NOISE_PIN] = 1'b1;   // clap pin left alone
                    end else if (cnt == '0) begin
                        pin_state[k] = 1'b1;
                    end
                end
            end
            if (accent_cnt != '0) begin
                accent_cnt = accent_cnt - 1'b1;
                if (accent_cnt == '0)
                    pin_state[ACCENT_PIN] = 1'b1;
            end
        end else if (it.status_byte[7:4] == NOTE_ON_NIBBLE && it.velocity != '0) begin
            // lowest numbered drum wins on duplicate notes
            for (k = 0; k < DRUMS_USED; k++) begin
                if (!hit && drum_note_cfg[k] == it.note_number) begin
                    pin_state[k] = 1'b0;
                    drum_cnt[k]  = (k == CLAP_DRUM) ? CLAP_LOAD : DRUM_LOAD;
                    hit          = 1'b1;
                end
            end
            if (it.velocity > accent_thr_cfg) begin
                accent_cnt            = ACCENT_LOAD;
                pin_state[ACCENT_PIN] = 1'b0;
            end
        end
        return pin_state;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random backpressure, checker, watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(99) >= ready_stall_pct);

    task automatic report_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_pins_q.size() == 0) begin
                report_error($sformatf("output transaction with nothing pending, pins %02h",
                                       o_trigger_pins));
            end else begin
                pins_due = exp_pins_q.pop_front();
                if (o_trigger_pins !== pins_due)
                    report_error($sformatf("trigger_pins expected %02h got %02h",
                                           pins_due, o_trigger_pins));
            end
        end
    end

    // counts cycles where neither channel moves a transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers. All calls start and end right after a rising edge.
    // valid is left high after acceptance only when the next send follows
    // in the same step; anything else that takes time lowers it first.
    // ------------------------------------------------------------------
    task automatic send_item(input logic cmd, input logic [7:0] status,
                             input logic [NOTE_W-1:0] note, input logic [NOTE_W-1:0] vel);
        t_item it;
        it.command     = cmd;
        it.status_byte = status;
        it.note_number = note;
        it.velocity    = vel;
        if ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_status_byte <= status;
        i_note_number <= note;
        i_velocity    <= vel;
        do @(posedge i_clk); while (!o_in_ready);
        exp_pins_q.push_back(step_pins(it));
    endtask

    task automatic send_tick();
        // junk in the ignored fields
        send_item(CMD_TICK, 8'($urandom), 7'($urandom), 7'($urandom));
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_tick();
    endtask

    // drain: stop sending, let every pending result out, then a few more cycles
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (exp_pins_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup, access, then the bus is released before the task returns
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < MAX_DRUMS)
            drum_note_cfg[idx] = value[NOTE_W-1:0];
        else if (idx == REG_ACCENT_THR)
            accent_thr_cfg = value[NOTE_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic write_all_notes(input logic [31:0] value);
        int k;
        for (k = 0; k < MAX_DRUMS; k++)
            write_reg(REG_DRUM0 + IDX_W'(k), value);
    endtask

    task automatic restore_default_config();
        int k;
        for (k = 0; k < MAX_DRUMS; k++)
            write_reg(REG_DRUM0 + IDX_W'(k), 32'(NOTE_RESET[k]));
        write_reg(REG_ACCENT_THR, 32'(ACCENT_THR_RESET));
    endtask

    // notes from a narrow window so duplicates and near misses show up;
    // upper pwdata bits carry junk that the block must drop
    task automatic load_random_config();
        int k;
        int unsigned base;
        logic [31:0] value;
        base = $urandom_range(127 - 8);
        for (k = 0; k < MAX_DRUMS; k++) begin
            value      = $urandom;
            value[6:0] = 7'(base + $urandom_range(8));
            write_reg(REG_DRUM0 + IDX_W'(k), value);
        end
        value      = $urandom;
        value[6:0] = 7'($urandom_range(40, 127));
        write_reg(REG_ACCENT_THR, value);
    endtask

    // mostly well-formed note-ons on configured notes and ticks,
    // the rest off-status, note-off or unmatched noise
    task automatic send_random_item();
        int unsigned pick;
        logic [7:0] status;
        logic [NOTE_W-1:0] note;
        logic [NOTE_W-1:0] vel;
        pick   = $urandom_range(99);
        status = 8'($urandom);
        note   = 7'($urandom);
        vel    = 7'($urandom_range(1, 127));
        if (pick < 55) begin
            send_tick();
        end else if (pick < 88) begin
            status[7:4] = NOTE_ON_NIBBLE;
            if ($urandom_range(9) < 8)
                note = drum_note_cfg[$urandom_range(DRUMS_USED - 1)];
            send_item(CMD_EVENT, status, note, vel);
        end else begin
            if ($urandom_range(1) == 0)
                vel = '0;
            send_item(CMD_EVENT, status, note, vel);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // default notes: every drum, accent edges, ignored events
    task automatic test_event_decode();
        send_item(CMD_TICK, 8'hFF, 7'h7F, 7'h7F);          // fields ignored on tick
        send_item(CMD_TICK, 8'h90, 7'd36, 7'd127);
        send_item(CMD_EVENT, 8'h90, 7'd36, 7'd1);          // bass, no accent
        send_item(CMD_EVENT, 8'h9F, 7'd38, 7'd127);        // snare + accent, channel 15
        send_item(CMD_EVENT, 8'h80, 7'd39, 7'd127);        // note-off status
        send_item(CMD_EVENT, 8'h99, 7'd42, 7'd0);          // zero velocity
        send_item(CMD_EVENT, 8'hF0, 7'd46, 7'd127);        // system status
        send_item(CMD_EVENT, 8'h00, 7'd49, 7'd127);
        send_item(CMD_EVENT, 8'h95, 7'd0, 7'd101);         // no drum, accent fires
        send_item(CMD_EVENT, 8'h9A, 7'd127, 7'd100);       // velocity equals threshold
        send_item(CMD_EVENT, 8'h91, 7'd39, 7'd64);         // clap
        send_item(CMD_EVENT, 8'h92, 7'd42, 7'd64);
        send_item(CMD_EVENT, 8'h93, 7'd46, 7'd64);
        send_item(CMD_EVENT, 8'h94, 7'd49, 7'd64);
    endtask

    // extremes of the register range, duplicates, masking, unmapped index
    task automatic test_note_config();
        wait_idle();
        write_all_notes(32'h0000_0000);                    // every drum on note 0
        write_reg(REG_ACCENT_THR, 32'h0000_0000);
        write_reg(REG_UNMAPPED, 32'h0000_0037);            // must not land anywhere
        send_item(CMD_EVENT, 8'h90, 7'd0, 7'd1);           // drum 0 only, accent
        send_item(CMD_EVENT, 8'h9E, 7'd127, 7'd1);         // no drum, accent
        wait_idle();
        write_all_notes(32'hFFFF_FFFF);                    // masks to 127
        write_reg(REG_ACCENT_THR, 32'hFFFF_FF7F);          // 127, accent impossible
        send_item(CMD_EVENT, 8'h90, 7'd127, 7'd127);
        send_ticks(10);                                    // drums run out, accent halfway
        wait_idle();
        restore_default_config();
    endtask

    // full clap sequence, retrigger while the noise pin is low, then
    // let it run out completely
    task automatic test_clap_retrigger();
        send_item(CMD_EVENT, 8'h90, drum_note_cfg[CLAP_DRUM], 7'd127);
        send_ticks(66);
        send_item(CMD_EVENT, 8'h9C, drum_note_cfg[CLAP_DRUM], 7'd30);
        send_ticks(72);
    endtask

    task automatic test_random_traffic(input int unsigned gap_pct, input int unsigned stall_pct);
        wait_idle();
        load_random_config();
        send_gap_pct    = gap_pct;
        ready_stall_pct = stall_pct;
        repeat (RANDOM_ITEMS) begin
            // now and then hold off until the block has fully drained
            if ($urandom_range(99) == 0)
                wait_idle();
            send_random_item();
        end
    endtask

    initial begin
        reset_predictor();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_event_decode();
        test_note_config();
        send_gap_pct = 75;
        test_clap_retrigger();

        test_random_traffic(0, 0);
        test_random_traffic(75, 0);
        test_random_traffic(0, 75);
        test_random_traffic(29, 29);

        wait_idle();
        if (exp_pins_q.size() != 0)
            report_error($sformatf("%0d results never arrived", exp_pins_q.size()));
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
